>>> rtl/dnlw_pkg.sv
// ----------------------------------------------------------------------------
// dnlw_pkg
// Shared types, codes and result builders for the dns name label walker.
// ----------------------------------------------------------------------------
`default_nettype none

package dnlw_pkg;

    localparam int DEF_MSG_BYTES  = 512;
    localparam int DEF_MAX_LABELS = 32;
    localparam int DEF_MAX_HOPS   = 16;

    // walk position, pointer target and adder result widths
    localparam int POS_W = 10;
    localparam int TGT_W = 14;
    localparam int SUM_W = 15;

    localparam logic [7:0] PTR_TAG     = 8'hc0;
    localparam logic [7:0] PTR_HI_MASK = 8'h3f;

    typedef enum logic [0:0] {
        OP_LOAD  = 1'b0,
        OP_PARSE = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_LABEL = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_BAD_PTR = 2'd1,
        ERR_TRUNC   = 2'd2,
        ERR_LIMIT   = 2'd3
    } err_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEN_CHK,
        ST_LEN_RD,
        ST_PTR_CHK,
        ST_PTR_RD,
        ST_TGT_CHK,
        ST_LBL_CHK
    } state_t;

    typedef struct packed {
        opcode_t      opcode;
        logic [8:0]   offset;
        logic [7:0]   data_byte;
        logic [9:0]   msg_end;
    } in_item_t;

    typedef struct packed {
        kind_t        kind;
        logic [8:0]   label_offset;
        logic [7:0]   label_len;
        logic [9:0]   next_offset;
        err_t         error_code;
        logic         last;
    } out_item_t;

    typedef struct packed {
        logic [TGT_W-1:0] a;
        logic [7:0]       b;
        logic [POS_W-1:0] lim;
    } alu_req_t;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             ge;
        logic             gt;
    } alu_rsp_t;

    function automatic out_item_t make_label(input logic [8:0] loff, input logic [7:0] len);
        out_item_t r;
        r.kind         = KIND_LABEL;
        r.label_offset = loff;
        r.label_len    = len;
        r.next_offset  = '0;
        r.error_code   = ERR_NONE;
        r.last         = 1'b0;
        return r;
    endfunction

    function automatic out_item_t make_done(input logic [POS_W-1:0] nxt);
        out_item_t r;
        r.kind         = KIND_DONE;
        r.label_offset = '0;
        r.label_len    = '0;
        r.next_offset  = nxt;
        r.error_code   = ERR_NONE;
        r.last         = 1'b1;
        return r;
    endfunction

    function automatic out_item_t make_error(input err_t code);
        out_item_t r;
        r.kind         = KIND_ERROR;
        r.label_offset = '0;
        r.label_len    = '0;
        r.next_offset  = '0;
        r.error_code   = code;
        r.last         = 1'b1;
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/dnlw_in_if.sv
// ----------------------------------------------------------------------------
// dnlw_in_if
// Valid/ready channel carrying load and parse transactions.
// ----------------------------------------------------------------------------
`default_nettype none

interface dnlw_in_if
    import dnlw_pkg::*;
();
    logic     valid;
    logic     ready;
    in_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> rtl/dnlw_out_if.sv
// ----------------------------------------------------------------------------
// dnlw_out_if
// Valid/ready channel carrying label, completion and error transactions.
// ----------------------------------------------------------------------------
`default_nettype none

interface dnlw_out_if
    import dnlw_pkg::*;
();
    logic      valid;
    logic      ready;
    out_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> rtl/dnlw_ram.sv
// ----------------------------------------------------------------------------
// dnlw_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dnlw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    addr,
    input  wire logic [WIDTH-1:0] wdata,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/dnlw_alu.sv
// ----------------------------------------------------------------------------
// dnlw_alu
// Shared adder and end-of-message comparator used by every walk step.
// ----------------------------------------------------------------------------
`default_nettype none

module dnlw_alu
    import dnlw_pkg::*;
(
    input  wire alu_req_t req,
    output alu_rsp_t      rsp
);

    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] lim_ext;

    assign sum     = SUM_W'(req.a) + SUM_W'(req.b);
    assign lim_ext = SUM_W'(req.lim);

    assign rsp.sum = sum;
    assign rsp.ge  = (sum >= lim_ext);
    assign rsp.gt  = (sum > lim_ext);

endmodule

`default_nettype wire

>>> rtl/dnlw_walker.sv
// ----------------------------------------------------------------------------
// dnlw_walker
// Sequencer that loads the message store and walks labels and pointers.
// ----------------------------------------------------------------------------
`default_nettype none

module dnlw_walker
    import dnlw_pkg::*;
#(
    parameter int MSG_BYTES  = DEF_MSG_BYTES,
    parameter int MAX_LABELS = DEF_MAX_LABELS,
    parameter int MAX_HOPS   = DEF_MAX_HOPS,
    localparam int ADDR_W    = $clog2(MSG_BYTES)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire in_item_t          in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output out_item_t              out_data,
    output logic                   ram_we,
    output logic      [ADDR_W-1:0] ram_addr,
    output logic      [7:0]        ram_wdata,
    input  wire logic [7:0]        ram_rdata,
    output alu_req_t               alu_req,
    input  wire alu_rsp_t          alu_rsp
);

    localparam int LBL_W = $clog2(MAX_LABELS + 1);
    localparam int HOP_W = $clog2(MAX_HOPS + 1);

    state_t           state_reg, state_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] end_reg, end_next;
    logic [TGT_W-1:0] tgt_reg, tgt_next;
    logic [7:0]       size_reg, size_next;
    logic [5:0]       hi_reg, hi_next;
    logic [POS_W-1:0] resume_reg, resume_next;
    logic             resumed_reg, resumed_next;
    logic [LBL_W-1:0] labels_reg, labels_next;
    logic [HOP_W-1:0] hops_reg, hops_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_reg, out_next;

    logic             out_free;
    logic             emit;
    out_item_t        emit_item;
    logic [POS_W-1:0] sum_pos;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            resumed_reg   <= 1'b0;
            labels_reg    <= '0;
            hops_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            resumed_reg   <= resumed_next;
            labels_reg    <= labels_next;
            hops_reg      <= hops_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        end_reg    <= end_next;
        tgt_reg    <= tgt_next;
        size_reg   <= size_next;
        hi_reg     <= hi_next;
        resume_reg <= resume_next;
        out_reg    <= out_next;
    end

    assign out_free = !out_valid_reg || out_ready;
    assign sum_pos  = POS_W'(alu_rsp.sum);

    always_comb
    begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        end_next     = end_reg;
        tgt_next     = tgt_reg;
        size_next    = size_reg;
        hi_next      = hi_reg;
        resume_next  = resume_reg;
        resumed_next = resumed_reg;
        labels_next  = labels_reg;
        hops_next    = hops_reg;
        in_ready     = 1'b0;
        ram_we       = 1'b0;
        ram_addr     = ADDR_W'(pos_reg);
        ram_wdata    = in_data.data_byte;
        alu_req.a    = TGT_W'(pos_reg);
        alu_req.b    = 8'd0;
        alu_req.lim  = end_reg;
        emit         = 1'b0;
        emit_item    = make_error(ERR_NONE);

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_data.opcode == OP_LOAD)
                    begin
                        ram_we   = (32'(in_data.offset) < MSG_BYTES);
                        ram_addr = ADDR_W'(in_data.offset);
                    end
                    else
                    begin
                        pos_next     = POS_W'(in_data.offset);
                        end_next     = (32'(in_data.msg_end) > MSG_BYTES) ?
                                       POS_W'(MSG_BYTES) : in_data.msg_end;
                        resumed_next = 1'b0;
                        labels_next  = '0;
                        hops_next    = '0;
                        state_next   = ST_LEN_CHK;
                    end
                end
            end

            ST_LEN_CHK:
            begin
                // read of the length byte is issued here
                if (alu_rsp.ge)
                begin
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        emit_item  = make_error(ERR_TRUNC);
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_LEN_RD;
                end
            end

            ST_LEN_RD:
            begin
                alu_req.b = 8'd1;
                if (ram_rdata == 8'd0)
                begin
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        emit_item  = make_done(resumed_reg ? resume_reg : sum_pos);
                        state_next = ST_IDLE;
                    end
                end
                else if ((ram_rdata & PTR_TAG) == PTR_TAG)
                begin
                    hi_next    = 6'(ram_rdata & PTR_HI_MASK);
                    pos_next   = sum_pos;
                    state_next = ST_PTR_CHK;
                end
                else
                begin
                    size_next  = ram_rdata;
                    pos_next   = sum_pos;
                    state_next = ST_LBL_CHK;
                end
            end

            ST_PTR_CHK:
            begin
                if (alu_rsp.ge)
                begin
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        emit_item  = make_error(ERR_TRUNC);
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_PTR_RD;
                end
            end

            ST_PTR_RD:
            begin
                alu_req.b  = 8'd1;
                tgt_next   = {hi_reg, ram_rdata};
                pos_next   = sum_pos;
                // resume point is fixed by the first pointer only
                if (!resumed_reg)
                begin
                    resume_next  = sum_pos;
                    resumed_next = 1'b1;
                end
                state_next = ST_TGT_CHK;
            end

            ST_TGT_CHK:
            begin
                alu_req.a = tgt_reg;
                if (alu_rsp.ge || (hops_reg == HOP_W'(MAX_HOPS)))
                begin
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        emit_item  = make_error(alu_rsp.ge ? ERR_BAD_PTR : ERR_LIMIT);
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    hops_next  = hops_reg + HOP_W'(1);
                    pos_next   = POS_W'(tgt_reg);
                    state_next = ST_LEN_CHK;
                end
            end

            ST_LBL_CHK:
            begin
                alu_req.b = size_reg;
                if (out_free)
                begin
                    emit = 1'b1;
                    if (alu_rsp.gt)
                    begin
                        emit_item  = make_error(ERR_TRUNC);
                        state_next = ST_IDLE;
                    end
                    else if (labels_reg == LBL_W'(MAX_LABELS))
                    begin
                        emit_item  = make_error(ERR_LIMIT);
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        emit_item   = make_label(9'(pos_reg), size_reg);
                        pos_next    = sum_pos;
                        labels_next = labels_reg + LBL_W'(1);
                        state_next  = ST_LEN_CHK;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_next       = emit_item;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

>>> rtl/dns_name_label_walker.sv
// load: one byte per cycle while no parse is in progress, the block is ready again the next cycle
// parse: a bound check and a read per length byte, a bound check per label, and a bound check,
//   a read and a target check per pointer hop, then a return to idle before the next transaction;
//   the steps share the one adder/comparator and the single read port of the message store
// one result register decouples the output; a full register stalls the walk
// rst_n clears the sequencer and the output valid; the store is not cleared
// ----------------------------------------------------------------------------
// dns_name_label_walker
// Walks length-prefixed dns name labels with compression pointers.
// ----------------------------------------------------------------------------
`default_nettype none

module dns_name_label_walker
    import dnlw_pkg::*;
#(
    parameter int MSG_BYTES  = DEF_MSG_BYTES,
    parameter int MAX_LABELS = DEF_MAX_LABELS,
    parameter int MAX_HOPS   = DEF_MAX_HOPS
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    dnlw_in_if.sink    in_ch,
    dnlw_out_if.source out_ch
);

    localparam int ADDR_W = $clog2(MSG_BYTES);

    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [7:0]        ram_wdata;
    logic [7:0]        ram_rdata;
    alu_req_t          alu_req;
    alu_rsp_t          alu_rsp;

    dnlw_walker #(
        .MSG_BYTES  (MSG_BYTES),
        .MAX_LABELS (MAX_LABELS),
        .MAX_HOPS   (MAX_HOPS)
    ) u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .in_data   (in_ch.payload),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_data  (out_ch.payload),
        .ram_we    (ram_we),
        .ram_addr  (ram_addr),
        .ram_wdata (ram_wdata),
        .ram_rdata (ram_rdata),
        .alu_req   (alu_req),
        .alu_rsp   (alu_rsp)
    );

    dnlw_ram #(
        .WIDTH (8),
        .DEPTH (MSG_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    dnlw_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    // only label results leave last low
    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.payload.last == (out_ch.payload.kind != KIND_LABEL)))
        else $error("last flag does not match result kind");

    // error results always carry a cause, other results never do
    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |->
            ((out_ch.payload.kind == KIND_ERROR) == (out_ch.payload.error_code != ERR_NONE)))
        else $error("error code does not match result kind");

    // a parse transaction occupies the walker for at least the next cycle
    a_parse_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && (in_ch.payload.opcode == OP_PARSE)) |=> !in_ch.ready)
        else $error("input accepted right after a parse");

endmodule

`default_nettype wire

>>> dv/tb_dns_name_label_walker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dns_name_label_walker
// Loads message bytes and parses names through the valid/ready channels.
// Every accepted parse is predicted and its label, completion and error
// results are checked in order. Directed names and random names with random
// idling on both sides are used.
// ----------------------------------------------------------------------------

module tb_dns_name_label_walker;
    import dnlw_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_LIMIT = 20000;

    typedef struct {
        bit       barrier;
        int       phase_sel;
        in_item_t item;
    } stim_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic      drv_valid = 1'b0;
    in_item_t  drv_item = '0;
    logic      rx_ready = 1'b0;

    dnlw_in_if  in_ch ();
    dnlw_out_if out_ch ();

    assign in_ch.valid   = drv_valid;
    assign in_ch.payload = drv_item;
    assign out_ch.ready  = rx_ready;

    dns_name_label_walker dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // shadow store follows the generated transactions, model store the accepted ones
    logic [7:0] shadow_mem [DEF_MSG_BYTES];
    bit         shadow_set [DEF_MSG_BYTES];
    logic [7:0] model_mem [DEF_MSG_BYTES];

    stim_t     stim_queue [$];
    out_item_t walk_results [$];
    out_item_t awaited_results [$];
    int        name_starts [$];

    int tx_idle_pct [3] = '{14, 46, 0};
    int rx_idle_pct [3] = '{46, 14, 0};
    int idle_phase = 0;
    int issued_cnt = 0;
    int checked_cnt = 0;
    int mismatches = 0;
    int cycle_cnt = 0;

    function automatic out_item_t name_result(input kind_t k, input int loff, input int len,
                                              input int nxt, input err_t e);
        out_item_t r;
        r.kind         = k;
        r.label_offset = loff[8:0];
        r.label_len    = len[7:0];
        r.next_offset  = nxt[9:0];
        r.error_code   = e;
        r.last         = (k != KIND_LABEL);
        return r;
    endfunction

    function automatic void add_walk_result(input out_item_t r);
        walk_results.insert(walk_results.size(), r);
    endfunction

    function automatic void add_stim(input stim_t s);
        stim_queue.insert(stim_queue.size(), s);
    endfunction

    function automatic int store_byte(input bit gen_side, input int addr);
        return gen_side ? int'(shadow_mem[addr]) : int'(model_mem[addr]);
    endfunction

    // walks one name into walk_results; on the shadow side it stops at the
    // first unwritten byte it would read and returns that address
    function automatic int walk_name(input bit gen_side, input int start, input int lim_raw);
        int lim;
        int pos;
        int resume;
        bit resumed;
        int labels;
        int hops;
        int sz;
        int tgt;
        walk_results.delete();
        lim = (lim_raw > DEF_MSG_BYTES) ? DEF_MSG_BYTES : lim_raw;
        pos = start;
        resume = 0;
        resumed = 1'b0;
        labels = 0;
        hops = 0;
        while (1)
        begin
            if (pos >= lim)
            begin
                add_walk_result(name_result(KIND_ERROR, 0, 0, 0, ERR_TRUNC));
                return -1;
            end
            if (gen_side && !shadow_set[pos])
                return pos;
            sz = store_byte(gen_side, pos);
            pos++;
            if (sz == 0)
                break;
            if ((sz & PTR_TAG) == PTR_TAG)
            begin
                if (pos >= lim)
                begin
                    add_walk_result(name_result(KIND_ERROR, 0, 0, 0, ERR_TRUNC));
                    return -1;
                end
                if (gen_side && !shadow_set[pos])
                    return pos;
                tgt = ((sz & PTR_HI_MASK) << 8) | store_byte(gen_side, pos);
                pos++;
                // resume point is fixed by the first pointer only
                if (!resumed)
                begin
                    resume = pos;
                    resumed = 1'b1;
                end
                if (tgt >= lim)
                begin
                    add_walk_result(name_result(KIND_ERROR, 0, 0, 0, ERR_BAD_PTR));
                    return -1;
                end
                hops++;
                if (hops > DEF_MAX_HOPS)
                begin
                    add_walk_result(name_result(KIND_ERROR, 0, 0, 0, ERR_LIMIT));
                    return -1;
                end
                pos = tgt;
                continue;
            end
            if (pos + sz > lim)
            begin
                add_walk_result(name_result(KIND_ERROR, 0, 0, 0, ERR_TRUNC));
                return -1;
            end
            if (labels >= DEF_MAX_LABELS)
            begin
                add_walk_result(name_result(KIND_ERROR, 0, 0, 0, ERR_LIMIT));
                return -1;
            end
            add_walk_result(name_result(KIND_LABEL, pos, sz, 0, ERR_NONE));
            labels++;
            pos += sz;
        end
        if (!resumed)
            resume = pos;
        add_walk_result(name_result(KIND_DONE, 0, 0, resume, ERR_NONE));
        return -1;
    endfunction

    task automatic queue_load(input int addr, input int val);
        stim_t s;
        shadow_mem[addr] = val[7:0];
        shadow_set[addr] = 1'b1;
        s.barrier = 1'b0;
        s.phase_sel = 0;
        s.item.opcode = OP_LOAD;
        s.item.offset = addr[8:0];
        s.item.data_byte = val[7:0];
        s.item.msg_end = $urandom_range(1023);
        add_stim(s);
    endtask

    // loads every byte the walk would read before it was ever written
    task automatic queue_parse(input int start, input int lim);
        stim_t s;
        int gap;
        int fill;
        gap = walk_name(1'b1, start, lim);
        while (gap >= 0)
        begin
            case ($urandom_range(3))
                0, 1: fill = 0;
                2: fill = $urandom_range(1, 8);
                default: fill = $urandom_range(255);
            endcase
            queue_load(gap, fill);
            gap = walk_name(1'b1, start, lim);
        end
        s.barrier = 1'b0;
        s.phase_sel = 0;
        s.item.opcode = OP_PARSE;
        s.item.offset = start[8:0];
        s.item.data_byte = $urandom_range(255);
        s.item.msg_end = lim[9:0];
        add_stim(s);
    endtask

    task automatic queue_barrier(input int next_phase);
        stim_t s;
        s.barrier = 1'b1;
        s.phase_sel = next_phase;
        s.item = '0;
        add_stim(s);
    endtask

    task automatic build_and_parse();
        int base;
        int pos;
        int nlab;
        int len;
        int tgt;
        int lim;
        base = $urandom_range(480);
        pos = base;
        nlab = $urandom_range(4);
        for (int i = 0; i < nlab; i++)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(13, 191) : $urandom_range(1, 12);
            if (pos + len + 3 > 511)
                break;
            queue_load(pos, len);
            pos += 1 + len;
        end
        if (name_starts.size() != 0 && $urandom_range(1) == 1)
        begin
            if ($urandom_range(9) == 0)
                tgt = $urandom_range(16383);
            else
                tgt = name_starts[$urandom_range(name_starts.size() - 1)];
            queue_load(pos, PTR_TAG | (tgt >> 8));
            queue_load(pos + 1, tgt & 8'hff);
        end
        else
            queue_load(pos, 0);
        name_starts.insert(name_starts.size(), base);
        case ($urandom_range(9))
            0: lim = $urandom_range(512);
            1: lim = $urandom_range(513, 1023);
            default: lim = DEF_MSG_BYTES;
        endcase
        queue_parse(base, lim);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : stim_driver
        int    produced;
        bit    next_valid;
        stim_t head;
        if (!rst_n)
        begin
            drv_valid <= 1'b0;
            drv_item <= '0;
            issued_cnt <= 0;
            idle_phase <= 0;
        end
        else
        begin
            produced = 0;
            if (drv_valid && in_ch.ready)
            begin
                if (drv_item.opcode == OP_LOAD)
                    model_mem[drv_item.offset] = drv_item.data_byte;
                else
                begin
                    void'(walk_name(1'b0, drv_item.offset, drv_item.msg_end));
                    foreach (walk_results[i])
                        awaited_results.insert(awaited_results.size(), walk_results[i]);
                    produced = walk_results.size();
                end
            end
            issued_cnt <= issued_cnt + produced;
            if (!(drv_valid && !in_ch.ready))
            begin
                next_valid = 1'b0;
                if (stim_queue.size() != 0)
                begin
                    if (stim_queue[0].barrier)
                    begin
                        // hold off until every outstanding result is back
                        if (issued_cnt + produced == checked_cnt)
                        begin
                            head = stim_queue.pop_front();
                            idle_phase <= head.phase_sel;
                        end
                    end
                    else if ($urandom_range(99) >= tx_idle_pct[idle_phase])
                    begin
                        head = stim_queue.pop_front();
                        drv_item <= head.item;
                        next_valid = 1'b1;
                    end
                end
                drv_valid <= next_valid;
            end
        end
    end

    task automatic check_field(input string fname, input int want, input int got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", fname, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        out_item_t want;
        if (!rst_n)
        begin
            rx_ready <= 1'b0;
            checked_cnt <= 0;
        end
        else
        begin
            if (out_ch.valid && rx_ready)
            begin
                if (issued_cnt > checked_cnt)
                begin
                    want = awaited_results.pop_front();
                    check_field("kind", want.kind, out_ch.payload.kind);
                    check_field("label_offset", want.label_offset, out_ch.payload.label_offset);
                    check_field("label_len", want.label_len, out_ch.payload.label_len);
                    check_field("next_offset", want.next_offset, out_ch.payload.next_offset);
                    check_field("error_code", want.error_code, out_ch.payload.error_code);
                    check_field("last", want.last, out_ch.payload.last);
                    checked_cnt <= checked_cnt + 1;
                end
                else
                begin
                    $error("unexpected result transaction, kind %0d", out_ch.payload.kind);
                    mismatches++;
                end
            end
            rx_ready <= ($urandom_range(99) >= rx_idle_pct[idle_phase]);
        end
    end

    always @(posedge clk)
    begin : cycle_guard
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("dns_name_label_walker test failed");
            $finish;
        end
    end

    initial
    begin : run_ctrl
        int drain;

        // plain name, root name, then a label followed by a pointer to the first
        queue_load(0, 3);
        queue_load(4, 1);
        queue_load(6, 0);
        queue_parse(0, 512);
        queue_load(10, 0);
        queue_parse(10, 512);
        queue_load(20, 2);
        queue_load(23, PTR_TAG);
        queue_load(24, 0);
        queue_parse(20, 512);
        // longest label, and length bytes with top bits 10 and 01
        queue_load(100, 191);
        queue_load(292, 0);
        queue_parse(100, 512);
        queue_load(300, 8'h41);
        queue_load(366, 0);
        queue_parse(300, 512);
        // truncated: length byte, label body, pointer low byte
        queue_parse(0, 0);
        queue_parse(0, 3);
        queue_parse(23, 24);
        // pointer targets beyond the message, and a clamped message length
        queue_load(30, 8'hff);
        queue_load(31, 8'hff);
        queue_parse(30, 512);
        queue_load(40, 8'hc1);
        queue_load(41, 0);
        queue_parse(40, 256);
        queue_parse(40, 1023);
        // self loop, then a chain of exactly the hop limit and one past it
        queue_load(50, PTR_TAG);
        queue_load(51, 50);
        queue_parse(50, 512);
        for (int k = 0; k < DEF_MAX_HOPS; k++)
        begin
            queue_load(58 + 2 * k, PTR_TAG);
            queue_load(59 + 2 * k, 60 + 2 * k);
        end
        queue_load(58 + 2 * DEF_MAX_HOPS, 0);
        queue_parse(58, 512);
        queue_load(56, PTR_TAG);
        queue_load(57, 58);
        queue_parse(56, 512);
        // exactly the label limit, then one label more
        for (int k = 0; k < DEF_MAX_LABELS; k++)
            queue_load(400 + 2 * k, 1);
        queue_load(400 + 2 * DEF_MAX_LABELS, 0);
        queue_parse(400, 512);
        queue_load(398, 1);
        queue_parse(398, 512);
        // name at the very end of the store
        queue_load(511, 0);
        queue_parse(511, 512);

        for (int round = 0; round < 6; round++)
        begin
            if (round == 2)
                queue_barrier(1);
            if (round == 4)
                queue_barrier(2);
            if ($urandom_range(99) < 70)
                build_and_parse();
            else
            begin
                repeat ($urandom_range(3))
                    queue_load($urandom_range(511), $urandom_range(255));
                queue_parse($urandom_range(511), $urandom_range(512));
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // sampled mid-cycle so the driver's updates at the edge are settled
        while (stim_queue.size() != 0 || drv_valid)
            @(negedge clk);
        drain = 0;
        while (issued_cnt != checked_cnt && drain < DRAIN_LIMIT)
        begin
            @(negedge clk);
            drain++;
        end
        repeat (40) @(posedge clk);
        if (awaited_results.size() != 0)
        begin
            $error("%0d expected results never arrived", awaited_results.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("dns_name_label_walker test passed");
        else
            $display("dns_name_label_walker test failed");
        $finish;
    end

endmodule
